### src/ipfrag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfrag_pkg
// Shared types and constants of the IPv4 TCP fragment splitter.
// ----------------------------------------------------------------------------
package ipfrag_pkg;

   localparam int unsigned MAX_FRAME_PAYLOAD = 16384;
   localparam int unsigned LINK_HEADER_BYTES = 14;

   localparam logic [10:0] MTU_RESET = 11'd512;
   localparam logic [10:0] MTU_MIN   = 11'd256;
   localparam logic [10:0] MTU_MAX   = 11'd1500;
   localparam logic [7:0]  PROTO_TCP = 8'd6;

   localparam int unsigned MF_BIT = 13;
   localparam int unsigned DF_BIT = 14;

   typedef enum logic [1:0] {
      KIND_PASS  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_SPLIT = 2'd2
   } ipfrag_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } ipfrag_state_type;

   // one classified packet, as queued between front and back
   typedef struct packed {
      ipfrag_kind_type kind;
      logic [5:0]      header_length;
      logic [14:0]     remain;
      logic [15:0]     offset;
      logic [14:0]     start;
      logic            orig_mf;
      logic [15:0]     partial_sum;
      logic [10:0]     mtu;
   } ipfrag_job_type;

endpackage

### src/ipfrag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfrag_front
// Accepts packet descriptors, classifies them and queues the jobs.
// ----------------------------------------------------------------------------
module ipfrag_front
   import ipfrag_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  logic [7:0]     req_protocol,
   input  logic [15:0]    req_total_length,
   input  logic [5:0]     req_header_length,
   input  logic [14:0]    req_frame_payload_length,
   input  logic [15:0]    req_fragment_field,
   input  logic [15:0]    req_header_partial_sum,
   input  logic [10:0]    mtu_bytes,
   output logic           job_valid,
   output ipfrag_job_type job,
   input  logic           job_pop
);

   localparam logic [14:0] PAYLOAD_CAP = 15'(MAX_FRAME_PAYLOAD);
   localparam logic [14:0] LINK_BYTES  = 15'(LINK_HEADER_BYTES);

   ipfrag_job_type queue_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   logic [10:0]    mtu;
   logic [14:0]    remain;
   logic           accept;
   ipfrag_job_type new_job;

   always_comb begin
      priority if (mtu_bytes < MTU_MIN) begin
         mtu = MTU_MIN;
      end else if (mtu_bytes > MTU_MAX) begin
         mtu = MTU_MAX;
      end else begin
         mtu = mtu_bytes;
      end
      remain = (req_frame_payload_length > PAYLOAD_CAP) ? PAYLOAD_CAP
                                                          : req_frame_payload_length;

      new_job.header_length = req_header_length;
      new_job.remain        = remain;
      new_job.offset        = {req_fragment_field[12:0], 3'b000};
      new_job.start         = LINK_BYTES + {9'd0, req_header_length};
      new_job.orig_mf       = req_fragment_field[MF_BIT];
      new_job.partial_sum   = req_header_partial_sum;
      new_job.mtu           = mtu;
      priority if (req_protocol != PROTO_TCP || req_total_length <= {5'd0, mtu}) begin
         new_job.kind = KIND_PASS;
      end else if (remain == 15'd0) begin
         new_job.kind = KIND_EMPTY;
      end else begin
         new_job.kind = KIND_SPLIT;
      end
   end

   assign busy      = (count_ff == 2'd2);
   assign accept    = start && !busy;
   assign job_valid = (count_ff != 2'd0);
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

### src/ipfrag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfrag_back
// Walks one queued job at a time and emits one result per cycle while running.
// ----------------------------------------------------------------------------
module ipfrag_back
   import ipfrag_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           job_valid,
   input  ipfrag_job_type job,
   output logic           job_pop,
   output logic           rsp_valid,
   output logic           rsp_verdict,
   output logic           rsp_is_fragment,
   output logic           rsp_last,
   output logic [14:0]    rsp_payload_start,
   output logic [10:0]    rsp_payload_length,
   output logic [10:0]    rsp_new_total_length,
   output logic [15:0]    rsp_new_fragment_field,
   output logic [15:0]    rsp_new_checksum
);

   ipfrag_state_type state_ff, state_in;
   ipfrag_job_type   job_ff, job_in;

   logic        valid_ff, valid_in;
   logic        verdict_ff, verdict_in;
   logic        frag_ff, frag_in;
   logic        last_ff, last_in;
   logic [14:0] start_ff, start_in;
   logic [10:0] len_ff, len_in;
   logic [10:0] tot_ff, tot_in;
   logic [15:0] ff_ff, ff_in;
   logic [15:0] csum_ff, csum_in;

   logic [10:0] len;
   logic [14:0] remain_next;
   logic [10:0] tot;
   logic [15:0] ffield;
   logic [17:0] sum;
   logic [16:0] fold1;
   logic [16:0] fold2;
   logic        done;

   // slice arithmetic for the current fragment
   always_comb begin
      len         = (job_ff.remain > {4'd0, job_ff.mtu}) ? job_ff.mtu : job_ff.remain[10:0];
      remain_next = job_ff.remain - {4'd0, len};
      tot         = {5'd0, job_ff.header_length} + len;
      ffield      = {1'b0, 1'b1, (remain_next != 15'd0) || job_ff.orig_mf,
                     job_ff.offset[15:3]};
      sum         = {2'd0, job_ff.partial_sum} + {7'd0, tot} + {2'd0, ffield};
      fold1       = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
      fold2       = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      job_pop    = 1'b0;
      done       = 1'b0;
      valid_in   = 1'b0;
      verdict_in = 1'b0;
      frag_in    = 1'b0;
      last_in    = 1'b1;
      start_in   = 15'd0;
      len_in     = 11'd0;
      tot_in     = 11'd0;
      ff_in      = 16'd0;
      csum_in    = 16'd0;

      unique case (state_ff)
         ST_IDLE: begin
            done = 1'b1;
         end
         ST_RUN: begin
            valid_in = 1'b1;
            unique case (job_ff.kind)
               KIND_PASS: begin
                  done = 1'b1;
               end
               KIND_EMPTY: begin
                  verdict_in = 1'b1;
                  done       = 1'b1;
               end
               KIND_SPLIT: begin
                  verdict_in    = 1'b1;
                  frag_in       = 1'b1;
                  last_in       = (remain_next == 15'd0);
                  start_in      = job_ff.start;
                  len_in        = len;
                  tot_in        = tot;
                  ff_in         = ffield;
                  csum_in       = ~fold2[15:0];
                  done          = (remain_next == 15'd0);
                  job_in.remain = remain_next;
                  job_in.start  = job_ff.start + {4'd0, len};
                  job_in.offset = job_ff.offset + {5'd0, len};
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         default: begin
            done = 1'b1;
         end
      endcase

      // pick up the next job as soon as the current one finishes
      if (done) begin
         if (job_valid) begin
            job_pop  = 1'b1;
            job_in   = job;
            state_in = ST_RUN;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      verdict_ff <= verdict_in;
      frag_ff    <= frag_in;
      last_ff    <= last_in;
      start_ff   <= start_in;
      len_ff     <= len_in;
      tot_ff     <= tot_in;
      ff_ff      <= ff_in;
      csum_ff    <= csum_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_verdict            = verdict_ff;
   assign rsp_is_fragment        = frag_ff;
   assign rsp_last               = last_ff;
   assign rsp_payload_start      = start_ff;
   assign rsp_payload_length     = len_ff;
   assign rsp_new_total_length   = tot_ff;
   assign rsp_new_fragment_field = ff_ff;
   assign rsp_new_checksum       = csum_ff;

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("job popped from empty queue");

   a_frag_drops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_fragment |-> rsp_verdict && rsp_payload_length != 11'd0)
      else $error("fragment without drop verdict or payload");

   a_split_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_is_fragment)
      else $error("split interrupted before last fragment");

   a_df_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_fragment |-> rsp_new_fragment_field[DF_BIT])
      else $error("fragment without DF");

endmodule

### src/ipv4_tcp_fragment_splitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_tcp_fragment_splitter_unit
// Splits oversize IPv4 TCP packet descriptors into fragment descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the req_ fields and raise start; the item is taken at an
//   edge where start is high and busy is low. A two-entry queue sits
//   between the classifier and the fragment sequencer, so busy rises only
//   when two packets are waiting.
//   Output: each result shows for one cycle with rsp_valid high; rsp_last
//   marks the final result of a packet. The receiver cannot stall.
//   Throughput: the sequencer emits one result per cycle while it has a
//   job; a packet yields one result for a pass-through or empty drop,
//   otherwise one per fragment, ceil(payload / mtu), up to 64. An accepted
//   packet passes the queue, job and result registers to its first result.
//   Config: csr_mtu_bytes is written when csr_valid is high (csr_ready is
//   always high); write only while the block is idle.
//   Reset: clears the queue and sequencer and sets the MTU to 512.
// ----------------------------------------------------------------------------
module ipv4_tcp_fragment_splitter_unit
   import ipfrag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_protocol,
   input  logic [15:0] req_total_length,
   input  logic [5:0]  req_header_length,
   input  logic [14:0] req_frame_payload_length,
   input  logic [15:0] req_fragment_field,
   input  logic [15:0] req_header_partial_sum,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_mtu_bytes,
   output logic        rsp_valid,
   output logic        rsp_verdict,
   output logic        rsp_is_fragment,
   output logic        rsp_last,
   output logic [14:0] rsp_payload_start,
   output logic [10:0] rsp_payload_length,
   output logic [10:0] rsp_new_total_length,
   output logic [15:0] rsp_new_fragment_field,
   output logic [15:0] rsp_new_checksum
);

   logic [10:0]    mtu_ff, mtu_in;
   logic           job_valid;
   logic           job_pop;
   ipfrag_job_type job;

   assign csr_ready = 1'b1;
   assign mtu_in    = (csr_valid && csr_ready) ? csr_mtu_bytes : mtu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff <= MTU_RESET;
      end else begin
         mtu_ff <= mtu_in;
      end
   end

   ipfrag_front u_front (
      .clock                    (clock),
      .reset                    (reset),
      .start                    (start),
      .busy                     (busy),
      .req_protocol             (req_protocol),
      .req_total_length         (req_total_length),
      .req_header_length        (req_header_length),
      .req_frame_payload_length (req_frame_payload_length),
      .req_fragment_field       (req_fragment_field),
      .req_header_partial_sum   (req_header_partial_sum),
      .mtu_bytes                (mtu_ff),
      .job_valid                (job_valid),
      .job                      (job),
      .job_pop                  (job_pop)
   );

   ipfrag_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .job_valid              (job_valid),
      .job                    (job),
      .job_pop                (job_pop),
      .rsp_valid              (rsp_valid),
      .rsp_verdict            (rsp_verdict),
      .rsp_is_fragment        (rsp_is_fragment),
      .rsp_last               (rsp_last),
      .rsp_payload_start      (rsp_payload_start),
      .rsp_payload_length     (rsp_payload_length),
      .rsp_new_total_length   (rsp_new_total_length),
      .rsp_new_fragment_field (rsp_new_fragment_field),
      .rsp_new_checksum       (rsp_new_checksum)
   );

endmodule
